[src/assembly_line_tokenizer_core_assert.svh]
// Assertion macros for the checker module of the line tokeniser.
`ifndef ASSEMBLY_LINE_TOKENIZER_CORE_ASSERT_SVH
`define ASSEMBLY_LINE_TOKENIZER_CORE_ASSERT_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define ALTOK_ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Concurrent assertion on the block clock and reset.
`define ALTOK_ASSERT(lbl, prop, msg) \
  `ALTOK_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

[src/altok_pkg.sv]
// Types and constants of the assembly line tokeniser.
package altok_pkg;

  // Line phase, one-hot.
  typedef enum logic [4:0] {
    PH_IDLE  = 5'b00001,
    PH_ADDR  = 5'b00010,
    PH_LABEL = 5'b00100,
    PH_COMP  = 5'b01000,
    PH_JUMP  = 5'b10000
  } phase_e;

  localparam logic [1:0] KIND_ADDR  = 2'd0;
  localparam logic [1:0] KIND_COMP  = 2'd1;
  localparam logic [1:0] KIND_LABEL = 2'd2;

  localparam logic [1:0] TAG_SYM  = 2'd0;
  localparam logic [1:0] TAG_DEST = 2'd1;
  localparam logic [1:0] TAG_COMP = 2'd2;
  localparam logic [1:0] TAG_JUMP = 2'd3;

  localparam logic [7:0] CH_AT     = 8'h40;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;

  // Layout of the result tuser field, highest bit first.
  typedef struct packed {
    logic       field_overflow;
    logic       has_char;
    logic [1:0] field_tag;
    logic [1:0] command_kind;
  } res_user_t;

endpackage

[src/assembly_line_tokenizer_core.sv]
// Streaming tokeniser for lines of assembly source, one source byte per beat.
// A source beat is registered, then processed into the result register, which offers its
// first result beat. Throughput: one source beat per cycle while m_axis_tready is high and
// each byte gives at most one result; a byte that gives n results (n is at most
// FIELD_CHARS + 1) holds the result register until all n have been taken.
// Reset clears the line state and both pipeline registers; no clearing pass is needed.
module assembly_line_tokenizer_core #(
  parameter int FIELD_CHARS = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] source_byte
  input  logic       s_axis_tlast,   // end_of_source
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] char_code
  output logic [5:0] m_axis_tuser,   // [1:0] command_kind, [3:2] field_tag, [4] has_char,
                                     // [5] field_overflow
  output logic       m_axis_tlast    // last_of_run
);

  localparam int CntW = $clog2(FIELD_CHARS + 1);
  localparam logic [CntW-1:0] CntMax = CntW'(FIELD_CHARS);
  localparam logic [CntW-1:0] CntOne = CntW'(1);

  // Input register.
  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       in_eos_q;

  // Line state.
  altok_pkg::phase_e phase_q, phase_d;
  logic            in_comment_q, in_comment_d;
  logic            skip_q, skip_d;
  logic [7:0]      held_char_q, held_char_d;
  logic            held_valid_q, held_valid_d;
  logic [7:0]      comp_buf_q [FIELD_CHARS];
  logic [7:0]      comp_buf_d [FIELD_CHARS];
  logic [CntW-1:0] comp_cnt_q, comp_cnt_d;
  logic [CntW-1:0] jump_cnt_q, jump_cnt_d;
  logic            ovf_q, ovf_d;

  // Result register: a run of characters followed by an optional end-of-command marker.
  logic [7:0]      bat_chars_q [FIELD_CHARS];
  logic [7:0]      bat_chars_d [FIELD_CHARS];
  logic [CntW-1:0] bat_cnt_q, bat_cnt_d;
  logic [1:0]      bat_tag_q, bat_tag_d;
  logic            bat_mark_q, bat_mark_d;
  logic [1:0]      bat_kind_q, bat_kind_d;
  logic            bat_ovf_q, bat_ovf_d;

  logic s_fire, m_fire, bat_valid, bat_last, bat_free, step;
  altok_pkg::res_user_t res_user;

  assign s_fire    = s_axis_tvalid && s_axis_tready;
  assign bat_valid = (bat_cnt_q != '0) || bat_mark_q;
  assign bat_last  = bat_mark_q ? (bat_cnt_q == '0) : (bat_cnt_q == CntOne);
  assign m_fire    = m_axis_tvalid && m_axis_tready;
  assign bat_free  = !bat_valid || (m_fire && bat_last);
  assign step      = in_valid_q && bat_free;
  assign s_axis_tready = !in_valid_q || step;

  always_comb begin : step_logic
    logic [7:0] b;
    logic       line_end;
    logic       keep;
    b = in_byte_q;
    line_end = 1'b0;
    keep = 1'b0;

    phase_d      = phase_q;
    in_comment_d = in_comment_q;
    skip_d       = skip_q;
    held_char_d  = held_char_q;
    held_valid_d = held_valid_q;
    comp_buf_d   = comp_buf_q;
    comp_cnt_d   = comp_cnt_q;
    jump_cnt_d   = jump_cnt_q;
    ovf_d        = ovf_q;

    bat_chars_d = comp_buf_q;
    bat_cnt_d   = '0;
    bat_tag_d   = altok_pkg::TAG_SYM;
    bat_mark_d  = 1'b0;

    if (skip_q) begin
      skip_d = 1'b0;
    end else if (b == altok_pkg::CH_CR || b == altok_pkg::CH_LF) begin
      line_end = 1'b1;
      if (b == altok_pkg::CH_CR) begin
        skip_d = 1'b1;
      end
    end else if (in_comment_q) begin
      keep = 1'b0;
    end else if (b == altok_pkg::CH_SPACE || b == altok_pkg::CH_TAB) begin
      keep = 1'b0;
    end else if (b == altok_pkg::CH_SLASH) begin
      in_comment_d = 1'b1;
    end else begin
      keep = 1'b1;
    end

    // The first kept character of a line decides its kind.
    if (keep && phase_q == altok_pkg::PH_IDLE) begin
      if (b == altok_pkg::CH_AT) begin
        phase_d = altok_pkg::PH_ADDR;
        keep = 1'b0;
      end else if (b == altok_pkg::CH_LPAREN) begin
        phase_d = altok_pkg::PH_LABEL;
        keep = 1'b0;
      end else begin
        phase_d = altok_pkg::PH_COMP;
      end
    end

    if (keep) begin
      case (phase_d)
        altok_pkg::PH_ADDR: begin
          bat_chars_d[0] = b;
          bat_cnt_d      = CntOne;
        end
        altok_pkg::PH_LABEL: begin
          // A label character goes out only once the next one shows it was not the last.
          if (held_valid_q) begin
            bat_chars_d[0] = held_char_q;
            bat_cnt_d      = CntOne;
          end
          held_char_d  = b;
          held_valid_d = 1'b1;
        end
        altok_pkg::PH_COMP: begin
          if (b == altok_pkg::CH_EQ) begin
            bat_chars_d = comp_buf_q;
            bat_cnt_d   = comp_cnt_q;
            bat_tag_d   = altok_pkg::TAG_DEST;
            comp_cnt_d  = '0;
          end else if (b == altok_pkg::CH_SEMI) begin
            bat_chars_d = comp_buf_q;
            bat_cnt_d   = comp_cnt_q;
            bat_tag_d   = altok_pkg::TAG_COMP;
            comp_cnt_d  = '0;
            phase_d     = altok_pkg::PH_JUMP;
          end else if (comp_cnt_q < CntMax) begin
            for (int i = 0; i < FIELD_CHARS; i++) begin
              if (comp_cnt_q == CntW'(i)) begin
                comp_buf_d[i] = b;
              end
            end
            comp_cnt_d = comp_cnt_q + CntOne;
          end else begin
            ovf_d = 1'b1;
          end
        end
        altok_pkg::PH_JUMP: begin
          if (jump_cnt_q < CntMax) begin
            bat_chars_d[0] = b;
            bat_cnt_d      = CntOne;
            bat_tag_d      = altok_pkg::TAG_JUMP;
            jump_cnt_d     = jump_cnt_q + CntOne;
          end else begin
            ovf_d = 1'b1;
          end
        end
        default: begin
          keep = 1'b0;
        end
      endcase
    end

    // Kind and overflow cannot change between the results of one source byte.
    case (phase_d)
      altok_pkg::PH_ADDR:  bat_kind_d = altok_pkg::KIND_ADDR;
      altok_pkg::PH_LABEL: bat_kind_d = altok_pkg::KIND_LABEL;
      default:             bat_kind_d = altok_pkg::KIND_COMP;
    endcase
    bat_ovf_d = ovf_d;

    if (line_end || in_eos_q) begin
      // A dest flush on this byte has emptied the buffer, so at most one flush is pending.
      if (phase_d == altok_pkg::PH_COMP && comp_cnt_d != '0) begin
        bat_chars_d = comp_buf_d;
        bat_cnt_d   = comp_cnt_d;
        bat_tag_d   = altok_pkg::TAG_COMP;
      end
      if (phase_d != altok_pkg::PH_IDLE) begin
        bat_mark_d = 1'b1;
      end
      phase_d      = altok_pkg::PH_IDLE;
      in_comment_d = 1'b0;
      held_char_d  = '0;
      held_valid_d = 1'b0;
      comp_cnt_d   = '0;
      jump_cnt_d   = '0;
      ovf_d        = 1'b0;
    end
    if (in_eos_q) begin
      skip_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q   <= 1'b0;
      phase_q      <= altok_pkg::PH_IDLE;
      in_comment_q <= 1'b0;
      skip_q       <= 1'b0;
      held_valid_q <= 1'b0;
      comp_cnt_q   <= '0;
      jump_cnt_q   <= '0;
      ovf_q        <= 1'b0;
      bat_cnt_q    <= '0;
      bat_mark_q   <= 1'b0;
    end else begin
      if (s_fire) begin
        in_valid_q <= 1'b1;
      end else if (step) begin
        in_valid_q <= 1'b0;
      end
      if (step) begin
        phase_q      <= phase_d;
        in_comment_q <= in_comment_d;
        skip_q       <= skip_d;
        held_valid_q <= held_valid_d;
        comp_cnt_q   <= comp_cnt_d;
        jump_cnt_q   <= jump_cnt_d;
        ovf_q        <= ovf_d;
        bat_cnt_q    <= bat_cnt_d;
        bat_mark_q   <= bat_mark_d;
      end else if (m_fire) begin
        if (bat_cnt_q != '0) begin
          bat_cnt_q <= bat_cnt_q - CntOne;
        end else begin
          bat_mark_q <= 1'b0;
        end
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      in_byte_q <= s_axis_tdata;
      in_eos_q  <= s_axis_tlast;
    end
    if (step) begin
      held_char_q <= held_char_d;
      comp_buf_q  <= comp_buf_d;
      bat_chars_q <= bat_chars_d;
      bat_tag_q   <= bat_tag_d;
      bat_kind_q  <= bat_kind_d;
      bat_ovf_q   <= bat_ovf_d;
    end else if (m_fire && bat_cnt_q != '0) begin
      // The head character has gone; move the rest down one slot.
      for (int i = 0; i < FIELD_CHARS - 1; i++) begin
        bat_chars_q[i] <= bat_chars_q[i+1];
      end
    end
  end

  assign res_user.command_kind   = bat_kind_q;
  assign res_user.field_tag      = (bat_cnt_q != '0) ? bat_tag_q : altok_pkg::TAG_SYM;
  assign res_user.has_char       = (bat_cnt_q != '0);
  assign res_user.field_overflow = bat_ovf_q;

  assign m_axis_tvalid = bat_valid;
  assign m_axis_tdata  = (bat_cnt_q != '0) ? bat_chars_q[0] : 8'h00;
  assign m_axis_tuser  = res_user;
  assign m_axis_tlast  = bat_last;

endmodule

[src/altok_checker.sv]
// Port-level checker for the assembly line tokeniser, bound to the top level.
`include "assembly_line_tokenizer_core_assert.svh"

module altok_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tvalid,
  input logic       s_axis_tready,
  input logic [7:0] s_axis_tdata,
  input logic       s_axis_tlast,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic [5:0] m_axis_tuser,
  input logic       m_axis_tlast
);

  logic s_hold;
  assign s_hold = s_axis_tvalid && s_axis_tready && (s_axis_tdata == s_axis_tdata)
                  && (s_axis_tlast == s_axis_tlast);

  // A stalled result beat keeps its payload.
  `ALTOK_ASSERT(a_res_stable, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast), "result beat changed while stalled")

  // An end-of-command marker carries no character and closes the run of its source byte.
  `ALTOK_ASSERT(a_marker_form, m_axis_tvalid && !m_axis_tuser[4] |-> m_axis_tlast && m_axis_tdata == 8'h00 && m_axis_tuser[3:2] == 2'd0, "malformed end-of-command marker")

  // A run that is not finished continues on the next cycle.
  `ALTOK_ASSERT(a_run_continues, m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> m_axis_tvalid, "result run broken off")

  // Results of one source byte all belong to the same command.
  `ALTOK_ASSERT(a_run_kind, m_axis_tvalid && m_axis_tready && !m_axis_tlast && !s_hold |=> $stable(m_axis_tuser[1:0]), "command kind changed inside a run")

endmodule

bind assembly_line_tokenizer_core altok_checker u_altok_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .s_axis_tlast  (s_axis_tlast),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);
